### sv/hole_fit_allocator_defines.svh
// ----------------------------------------------------------------------------
// Hole fit allocator assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HOLE_FIT_ALLOCATOR_DEFINES_SVH
`define HOLE_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hole_fit_allocator: assertion failed");

// next-cycle implication
`define HFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hole_fit_allocator: assertion failed");

`else

`define HFA_ASSERT_IMP(lbl, ante, cons)
`define HFA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### sv/hfa_pkg.sv
// ----------------------------------------------------------------------------
// Hole fit allocator package
// Sizes, codes, beat types and the cell chain token shared by all modules.
// ----------------------------------------------------------------------------
package hfa_pkg;

  // table geometry
  localparam int MAX_HOLES = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CNT_W     = $clog2(MAX_HOLES + 1);

  // fixed beat field widths
  localparam int OP_W     = 2;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;
  localparam int HIDX_W   = 4;
  localparam int LEFT_W   = 16;
  localparam int SUM_W    = 20;
  localparam int MODE_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_REQ    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // placement policies (anything else acts as first fit)
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REQ_W-1:0] size;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HIDX_W-1:0]   hole_index;
    logic [LEFT_W-1:0]   hole_left;
    logic [SUM_W-1:0]    total_free;
  } out_beat_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] best;
  } token_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [SIZE_BITS-1:0] wr_data;
    logic [SIZE_BITS-1:0] req_size;
    logic [MODE_W-1:0]    fit_mode;
    logic [CNT_W-1:0]     hole_count;
  } cell_ctl_t;

endpackage

### sv/hfa_cell.sv
// ----------------------------------------------------------------------------
// Hole fit allocator cell
// Holds one hole size, checks the passing token against it and forwards the
// possibly updated token, registered, to the next cell.
// ----------------------------------------------------------------------------
module hfa_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [hfa_pkg::IDX_W-1:0] cell_idx,
  input  hfa_pkg::cell_ctl_t       ctl,
  input  hfa_pkg::token_t          tok_in,
  output hfa_pkg::token_t          tok_out
);
  import hfa_pkg::*;

  logic [SIZE_BITS-1:0] hole_r;
  token_t               tok_r;
  token_t               tok_nxt;
  logic                 loaded;
  logic                 fits;
  logic                 better;
  logic                 take;

  // hole storage, written by append or grant
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
      hole_r <= ctl.wr_data;
    end
  end

  // candidate check against the running choice
  always_comb begin
    loaded = ctl.hole_count > CNT_W'(cell_idx);
    fits   = loaded && (hole_r >= ctl.req_size);
    case (ctl.fit_mode)
      MODE_BEST:  better = hole_r < tok_in.best;
      MODE_WORST: better = hole_r > tok_in.best;
      default:    better = 1'b0;
    endcase
    take = tok_in.valid && fits && (!tok_in.found || better);
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.pick  = cell_idx;
      tok_nxt.best  = hole_r;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

### sv/hole_fit_allocator.sv
// ----------------------------------------------------------------------------
// Hole fit allocator
// First, best or worst fit placement of requests into a table of free holes,
// searched by a token that walks a chain of one cell per hole.
// ----------------------------------------------------------------------------
//  channel | ports                        | beat
//  --------+------------------------------+-----------------------------------
//  in      | in_valid, in_stall, in_data  | op, size
//  out     | out_valid, out_stall, out_data | status, hole_index, hole_left,
//          |                              | total_free
//  cfg     | cfg_wr_en, cfg_wr_data       | fit_mode
//
//  Clear, append, a refused request and an unknown op skip the search.
//  A searched request launches a token that crosses one cell per cycle;
//  then the result is captured and the chosen hole is written.
//  One item is in work at a time; the next beat is taken while a result
//  still waits in the output register. Reset empties the table at once.
//  Out stall only delays the finishing step.
// ----------------------------------------------------------------------------
`include "hole_fit_allocator_defines.svh"

module hole_fit_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hfa_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hfa_pkg::out_beat_t          out_data,
  input  logic                        cfg_wr_en,
  input  logic [hfa_pkg::MODE_W-1:0]  cfg_wr_data
);
  import hfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [MODE_W-1:0]    fit_mode_r;
  logic [OP_W-1:0]      op_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 failed_r, failed_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  token_t               launch_r, launch_nxt;
  token_t               res_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;
  out_beat_t            res_beat;
  cell_ctl_t            ctl;
  token_t               chain [MAX_HOLES+1];
  logic [MAX_HOLES-1:0] tok_valid_vec;
  logic                 in_acc;
  logic                 out_free;
  logic                 finish;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] grant_left;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == S_DONE) && out_free;
  assign grant_left = res_r.best - size_r;

  // cell chain
  assign chain[0] = launch_r;
  for (genvar k = 0; k < MAX_HOLES; k++) begin : g_cell
    hfa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .ctl      (ctl),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
    assign tok_valid_vec[k] = chain[k+1].valid;
  end

  always_comb begin
    ctl.wr_en      = wr_en;
    ctl.wr_idx     = wr_idx;
    ctl.wr_data    = wr_data;
    ctl.req_size   = size_r;
    ctl.fit_mode   = fit_mode_r;
    ctl.hole_count = count_r;
  end

  // sequencer and token launch
  always_comb begin
    state_nxt  = state_r;
    launch_nxt = launch_r;
    launch_nxt.valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_data.op == OP_REQ) && !failed_r) begin
            state_nxt        = S_SEARCH;
            launch_nxt.valid = 1'b1;
            launch_nxt.found = 1'b0;
            launch_nxt.pick  = '0;
            launch_nxt.best  = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (chain[MAX_HOLES].valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // finishing step: table update and result beat
  always_comb begin
    count_nxt  = count_r;
    failed_nxt = failed_r;
    sum_nxt    = sum_r;
    wr_en      = 1'b0;
    wr_idx     = count_r[IDX_W-1:0];
    wr_data    = size_r;
    res_beat   = '0;
    case (op_r)
      OP_CLEAR: begin
        count_nxt  = '0;
        failed_nxt = 1'b0;
        sum_nxt    = '0;
      end
      OP_APPEND: begin
        if (count_r == CNT_W'(MAX_HOLES)) begin
          res_beat.status = ST_FULL;
        end else begin
          wr_en     = finish;
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_r + SUM_W'(size_r);
          res_beat.hole_index = HIDX_W'(count_r[IDX_W-1:0]);
          res_beat.hole_left  = LEFT_W'(size_r);
        end
      end
      OP_REQ: begin
        if (failed_r) begin
          res_beat.status = ST_REFUSED;
        end else if (!res_r.found) begin
          failed_nxt      = 1'b1;
          res_beat.status = ST_NOFIT;
        end else begin
          wr_en   = finish;
          wr_idx  = res_r.pick;
          wr_data = grant_left;
          sum_nxt = sum_r - SUM_W'(size_r);
          res_beat.hole_index = HIDX_W'(res_r.pick);
          res_beat.hole_left  = LEFT_W'(grant_left);
        end
      end
      default: ;
    endcase
    res_beat.total_free = sum_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_mode_r  <= MODE_FIRST;
      count_r     <= '0;
      failed_r    <= 1'b0;
      sum_r       <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
      if (cfg_wr_en) begin
        fit_mode_r <= cfg_wr_data;
      end
      if (finish) begin
        count_r     <= count_nxt;
        failed_r    <= failed_nxt;
        sum_r       <= sum_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_data.op;
      size_r <= SIZE_BITS'(in_data.size);
    end
    if ((state_r == S_SEARCH) && chain[MAX_HOLES].valid) begin
      res_r <= chain[MAX_HOLES];
    end
    if (finish) begin
      out_data_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `HFA_ASSERT_IMP(a_one_token, 1'b1, $countones(tok_valid_vec) <= 1)
  `HFA_ASSERT_IMP(a_token_in_search, chain[MAX_HOLES].valid, state_r == S_SEARCH)
  `HFA_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_HOLES))
  `HFA_ASSERT_IMP(a_out_after_done, $rose(out_valid_r), $past(state_r == S_DONE))
  `HFA_ASSERT_NXT(a_nofit_sets_flag, finish && (op_r == OP_REQ) && !failed_r && !res_r.found, failed_r)

endmodule
